>>> hw/rtl/scs1a_pkg.sv
`default_nettype none

package scs1a_pkg;

    // flag bit positions in modifier_state
    localparam int unsigned FlagW      = 7;
    localparam int unsigned BitShift   = 0;
    localparam int unsigned BitCtl     = 1;
    localparam int unsigned BitAlt     = 2;
    localparam int unsigned BitCaps    = 3;
    localparam int unsigned BitNum     = 4;
    localparam int unsigned BitScroll  = 5;
    localparam int unsigned BitPrefix  = 6;

    typedef logic [7:0]       byte_t;
    typedef logic [FlagW-1:0] flags_t;

    // scancodes and special characters
    localparam byte_t CodePrefix   = 8'hE0;
    localparam byte_t CodeRelease  = 8'h80;
    localparam byte_t CodeLowMask  = 8'h7F;
    localparam byte_t CodeLCtl     = 8'h1D;
    localparam byte_t CodeRCtl     = 8'h9D;
    localparam byte_t CodeLShift   = 8'h2A;
    localparam byte_t CodeRShift   = 8'h36;
    localparam byte_t CodeLAlt     = 8'h38;
    localparam byte_t CodeRAlt     = 8'hB8;
    localparam byte_t CodeCaps     = 8'h3A;
    localparam byte_t CodeNum      = 8'h45;
    localparam byte_t CodeScroll   = 8'h46;
    localparam byte_t CharDel      = 8'hE9;
    localparam byte_t CaseFlip     = 8'h20;

    // modifier held by a key (make or break code with bit 7 already resolved)
    function automatic flags_t held_bit(input byte_t code);
        flags_t m;
        m = '0;
        case (code)
            CodeLCtl, CodeRCtl:     m[BitCtl]   = 1'b1;
            CodeLShift, CodeRShift: m[BitShift] = 1'b1;
            CodeLAlt, CodeRAlt:     m[BitAlt]   = 1'b1;
            default:                m = '0;
        endcase
        return m;
    endfunction

    function automatic flags_t lock_bit(input byte_t code);
        flags_t m;
        m = '0;
        case (code)
            CodeCaps:   m[BitCaps]   = 1'b1;
            CodeNum:    m[BitNum]    = 1'b1;
            CodeScroll: m[BitScroll] = 1'b1;
            default:    m = '0;
        endcase
        return m;
    endfunction

    // extended keys (E0 prefixed), common to the plain and shift maps
    function automatic byte_t rom_ext(input byte_t code);
        byte_t c;
        case (code)
            8'h9C:   c = 8'h0A;
            8'hB5:   c = 8'h2F;
            8'hC7:   c = 8'hE0;
            8'hC8:   c = 8'hE2;
            8'hC9:   c = 8'hE6;
            8'hCB:   c = 8'hE4;
            8'hCD:   c = 8'hE5;
            8'hCF:   c = 8'hE1;
            8'hD0:   c = 8'hE3;
            8'hD1:   c = 8'hE7;
            8'hD2:   c = 8'hE8;
            8'hD3:   c = 8'hE9;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // keypad and space, common to the plain and shift maps
    function automatic byte_t rom_pad(input byte_t code);
        byte_t c;
        case (code)
            8'h37:   c = 8'h2A;
            8'h39:   c = 8'h20;
            8'h47:   c = 8'h37;
            8'h48:   c = 8'h38;
            8'h49:   c = 8'h39;
            8'h4A:   c = 8'h2D;
            8'h4B:   c = 8'h34;
            8'h4C:   c = 8'h35;
            8'h4D:   c = 8'h36;
            8'h4E:   c = 8'h2B;
            8'h4F:   c = 8'h31;
            8'h50:   c = 8'h32;
            8'h51:   c = 8'h33;
            8'h52:   c = 8'h30;
            8'h53:   c = 8'h2E;
            default: c = rom_ext(code);
        endcase
        return c;
    endfunction

    function automatic byte_t rom_plain(input byte_t code);
        byte_t c;
        case (code)
            8'h01: c = 8'h1B;  8'h02: c = 8'h31;  8'h03: c = 8'h32;  8'h04: c = 8'h33;
            8'h05: c = 8'h34;  8'h06: c = 8'h35;  8'h07: c = 8'h36;  8'h08: c = 8'h37;
            8'h09: c = 8'h38;  8'h0A: c = 8'h39;  8'h0B: c = 8'h30;  8'h0C: c = 8'h2D;
            8'h0D: c = 8'h3D;  8'h0E: c = 8'h08;  8'h0F: c = 8'h09;
            8'h10: c = 8'h71;  8'h11: c = 8'h77;  8'h12: c = 8'h65;  8'h13: c = 8'h72;
            8'h14: c = 8'h74;  8'h15: c = 8'h79;  8'h16: c = 8'h75;  8'h17: c = 8'h69;
            8'h18: c = 8'h6F;  8'h19: c = 8'h70;  8'h1A: c = 8'h5B;  8'h1B: c = 8'h5D;
            8'h1C: c = 8'h0A;  8'h1E: c = 8'h61;  8'h1F: c = 8'h73;
            8'h20: c = 8'h64;  8'h21: c = 8'h66;  8'h22: c = 8'h67;  8'h23: c = 8'h68;
            8'h24: c = 8'h6A;  8'h25: c = 8'h6B;  8'h26: c = 8'h6C;  8'h27: c = 8'h3B;
            8'h28: c = 8'h27;  8'h29: c = 8'h60;  8'h2B: c = 8'h5C;  8'h2C: c = 8'h7A;
            8'h2D: c = 8'h78;  8'h2E: c = 8'h63;  8'h2F: c = 8'h76;
            8'h30: c = 8'h62;  8'h31: c = 8'h6E;  8'h32: c = 8'h6D;  8'h33: c = 8'h2C;
            8'h34: c = 8'h2E;  8'h35: c = 8'h2F;
            default: c = rom_pad(code);
        endcase
        return c;
    endfunction

    function automatic byte_t rom_shift(input byte_t code);
        byte_t c;
        case (code)
            8'h01: c = 8'h1B;  8'h02: c = 8'h21;  8'h03: c = 8'h40;  8'h04: c = 8'h23;
            8'h05: c = 8'h24;  8'h06: c = 8'h25;  8'h07: c = 8'h5E;  8'h08: c = 8'h26;
            8'h09: c = 8'h2A;  8'h0A: c = 8'h28;  8'h0B: c = 8'h29;  8'h0C: c = 8'h5F;
            8'h0D: c = 8'h2B;  8'h0E: c = 8'h08;  8'h0F: c = 8'h09;
            8'h10: c = 8'h51;  8'h11: c = 8'h57;  8'h12: c = 8'h45;  8'h13: c = 8'h52;
            8'h14: c = 8'h54;  8'h15: c = 8'h59;  8'h16: c = 8'h55;  8'h17: c = 8'h49;
            8'h18: c = 8'h4F;  8'h19: c = 8'h50;  8'h1A: c = 8'h7B;  8'h1B: c = 8'h7D;
            8'h1C: c = 8'h0A;  8'h1E: c = 8'h41;  8'h1F: c = 8'h53;
            8'h20: c = 8'h44;  8'h21: c = 8'h46;  8'h22: c = 8'h47;  8'h23: c = 8'h48;
            8'h24: c = 8'h4A;  8'h25: c = 8'h4B;  8'h26: c = 8'h4C;  8'h27: c = 8'h3A;
            8'h28: c = 8'h22;  8'h29: c = 8'h7E;  8'h2B: c = 8'h7C;  8'h2C: c = 8'h5A;
            8'h2D: c = 8'h58;  8'h2E: c = 8'h43;  8'h2F: c = 8'h56;
            8'h30: c = 8'h42;  8'h31: c = 8'h4E;  8'h32: c = 8'h4D;  8'h33: c = 8'h3C;
            8'h34: c = 8'h3E;  8'h35: c = 8'h3F;
            default: c = rom_pad(code);
        endcase
        return c;
    endfunction

    function automatic byte_t rom_ctl(input byte_t code);
        byte_t c;
        case (code)
            8'h10: c = 8'h11;  8'h11: c = 8'h17;  8'h12: c = 8'h05;  8'h13: c = 8'h12;
            8'h14: c = 8'h14;  8'h15: c = 8'h19;  8'h16: c = 8'h15;  8'h17: c = 8'h09;
            8'h18: c = 8'h0F;  8'h19: c = 8'h10;  8'h1C: c = 8'h0D;  8'h1E: c = 8'h01;
            8'h1F: c = 8'h13;
            8'h20: c = 8'h04;  8'h21: c = 8'h06;  8'h22: c = 8'h07;  8'h23: c = 8'h08;
            8'h24: c = 8'h0A;  8'h25: c = 8'h0B;  8'h26: c = 8'h0C;  8'h2B: c = 8'h1C;
            8'h2C: c = 8'h1A;  8'h2D: c = 8'h18;  8'h2E: c = 8'h03;  8'h2F: c = 8'h16;
            8'h30: c = 8'h02;  8'h31: c = 8'h0E;  8'h32: c = 8'h0D;  8'h35: c = 8'hEF;
            8'h97: c = 8'hE0;  8'hB5: c = 8'hEF;
            8'hC8: c = 8'hE2;  8'hC9: c = 8'hE6;  8'hCB: c = 8'hE4;  8'hCD: c = 8'hE5;
            8'hCF: c = 8'hE1;  8'hD0: c = 8'hE3;  8'hD1: c = 8'hE7;  8'hD2: c = 8'hE8;
            8'hD3: c = 8'hE9;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scancode_set1_to_ascii_top.sv
`default_nettype none

// Channel   Handshake             Payload
// -------   -------------------   -----------------------------------------
// input     in_valid / in_stall   scancode[7:0]
// output    out_valid / out_stall char_code[7:0], debug_request,
//                                 modifier_state[6:0]
//
// One word in, one word out. Two register stages: the scancode is captured,
// decoded against the current flags and written to the result register
// with the updated flags once it is free, so a new word is taken every
// cycle while out_stall is low. The flag register updates exactly when a
// result is loaded, which keeps back-to-back words consistent.
// rst_n (async, active low) clears both valid bits and all flags.
// out_stall holds the result; the input stage stalls only when it is full
// and the result register cannot be freed in the same cycle.

module scancode_set1_to_ascii_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] scancode,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      char_code,
    output logic            debug_request,
    output logic [6:0]      modifier_state
);

    // input stage
    logic                  s1_valid_reg;
    scs1a_pkg::byte_t      code_reg;

    // result stage; flags_reg always matches the word held in the result stage
    logic                  out_valid_reg;
    scs1a_pkg::byte_t      char_reg;
    logic                  dbg_reg;
    scs1a_pkg::flags_t     flags_reg;

    logic                  res_load;
    logic                  s1_load;

    scs1a_pkg::byte_t      code_adj;
    scs1a_pkg::byte_t      rom_char;
    scs1a_pkg::byte_t      char_next;
    logic                  dbg_next;
    scs1a_pkg::flags_t     flags_next;

    assign res_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !res_load;
    assign s1_load  = in_valid && !in_stall;

    // decode: prefix / release / press
    always_comb
    begin
        code_adj   = code_reg;
        flags_next = flags_reg;
        rom_char   = '0;
        char_next  = '0;
        dbg_next   = 1'b0;
        if (code_reg == scs1a_pkg::CodePrefix)
        begin
            flags_next[scs1a_pkg::BitPrefix] = 1'b1;
        end
        else if (code_reg[7])
        begin
            // break code: keep bit 7 only for extended keys
            if (!flags_reg[scs1a_pkg::BitPrefix])
                code_adj = code_reg & scs1a_pkg::CodeLowMask;
            flags_next = flags_reg & ~scs1a_pkg::held_bit(code_adj);
            flags_next[scs1a_pkg::BitPrefix] = 1'b0;
        end
        else
        begin
            if (flags_reg[scs1a_pkg::BitPrefix])
                code_adj = code_reg | scs1a_pkg::CodeRelease;
            flags_next[scs1a_pkg::BitPrefix] = 1'b0;
            flags_next = (flags_next | scs1a_pkg::held_bit(code_adj))
                         ^ scs1a_pkg::lock_bit(code_adj);
            if (flags_next[scs1a_pkg::BitCtl])
                rom_char = scs1a_pkg::rom_ctl(code_adj);
            else if (flags_next[scs1a_pkg::BitShift])
                rom_char = scs1a_pkg::rom_shift(code_adj);
            else
                rom_char = scs1a_pkg::rom_plain(code_adj);
            char_next = rom_char;
            if (flags_next[scs1a_pkg::BitCaps])
            begin
                if (rom_char inside {[8'h61:8'h7A]})
                    char_next = rom_char - scs1a_pkg::CaseFlip;
                else if (rom_char inside {[8'h41:8'h5A]})
                    char_next = rom_char + scs1a_pkg::CaseFlip;
            end
            dbg_next = flags_next[scs1a_pkg::BitCtl] && flags_next[scs1a_pkg::BitAlt]
                       && (char_next == scs1a_pkg::CharDel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (res_load)
                s1_valid_reg <= 1'b0;

            if (res_load)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            code_reg <= scancode;
        if (res_load)
        begin
            char_reg <= char_next;
            dbg_reg  <= dbg_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign char_code      = char_reg;
    assign debug_request  = dbg_reg;
    assign modifier_state = flags_reg;

endmodule

`default_nettype wire

>>> hw/rtl/scs1a_checker.sv
`default_nettype none

module scs1a_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] scancode,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] char_code,
    input wire logic       debug_request,
    input wire logic [6:0] modifier_state
);

    // stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(scancode))
        else $error("input word changed while stalled");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_code)
            && $stable(debug_request) && $stable(modifier_state))
        else $error("result word changed while stalled");

    // debug only on ctrl+alt+del
    a_dbg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && debug_request |-> char_code == scs1a_pkg::CharDel
            && modifier_state[scs1a_pkg::BitCtl] && modifier_state[scs1a_pkg::BitAlt])
        else $error("debug request without ctrl+alt+del");

    // a character comes only from a press, which consumes the prefix
    a_char_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_code != 8'h00 |-> !modifier_state[scs1a_pkg::BitPrefix])
        else $error("character with prefix still pending");

    // input side free whenever the result side is free
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result stage");

endmodule

bind scancode_set1_to_ascii_top scs1a_checker u_scs1a_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .scancode       (scancode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .char_code      (char_code),
    .debug_request  (debug_request),
    .modifier_state (modifier_state)
);

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;

    // a cycle with no accepted word on either side counts toward the watchdog
    localparam int IdleLimit   = 1000;
    localparam int RandomWords = 1400;
    localparam int DrainCycles = 10;

    // one decoded word as seen on the output channel
    typedef struct packed {
        scs1a_pkg::byte_t  ch;
        logic              dbg;
        scs1a_pkg::flags_t mods;
    } decoded_t;

    typedef enum int {MapPlain = 0, MapShift = 1, MapCtl = 2} map_sel_t;

    // Tracks the keyboard flags and keeps the decoded words still owed by the block.
    class scancode_checker;

        localparam scs1a_pkg::byte_t LowerA = 8'h61;
        localparam scs1a_pkg::byte_t LowerZ = 8'h7A;
        localparam scs1a_pkg::byte_t UpperA = 8'h41;
        localparam scs1a_pkg::byte_t UpperZ = 8'h5A;

        scs1a_pkg::byte_t  key_map[3][256];
        scs1a_pkg::flags_t latched_flags;
        decoded_t          pending_chars[$];
        int                failures;
        int                shown;

        function new();
            for (int m = 0; m < 3; m++)
                for (int k = 0; k < 256; k++)
                    key_map[m][k] = '0;
            load_row(MapPlain, 'h00, 128'h001B3132_33343536_37383930_2D3D0809);
            load_row(MapPlain, 'h10, 128'h71776572_74797569_6F705B5D_0A006173);
            load_row(MapPlain, 'h20, 128'h64666768_6A6B6C3B_2760005C_7A786376);
            load_row(MapPlain, 'h30, 128'h626E6D2C_2E2F002A_00200000_00000000);
            load_row(MapShift, 'h00, 128'h001B2140_2324255E_262A2829_5F2B0809);
            load_row(MapShift, 'h10, 128'h51574552_54595549_4F507B7D_0A004153);
            load_row(MapShift, 'h20, 128'h44464748_4A4B4C3A_227E007C_5A584356);
            load_row(MapShift, 'h30, 128'h424E4D3C_3E3F002A_00200000_00000000);
            // keypad and extended keys read the same with or without shift
            for (int m = MapPlain; m <= MapShift; m++)
            begin
                load_row(m, 'h40, 128'h00000000_00000037_38392D34_35362B31);
                load_row(m, 'h50, 128'h3233302E_00000000_00000000_00000000);
                load_row(m, 'hC0, 128'h00000000_000000E0_E2E600E4_00E500E1);
                load_row(m, 'hD0, 128'hE3E7E8E9_00000000_00000000_00000000);
                key_map[m]['h9C] = 8'h0A;
                key_map[m]['hB5] = 8'h2F;
            end
            load_row(MapCtl, 'h10, 128'h11170512_14191509_0F100000_0D000113);
            load_row(MapCtl, 'h20, 128'h04060708_0A0B0C00_0000001C_1A180316);
            load_row(MapCtl, 'h30, 128'h020E0D00_00EF0000_00000000_00000000);
            load_row(MapCtl, 'hC0, 128'h00000000_00000000_E2E600E4_00E500E1);
            load_row(MapCtl, 'hD0, 128'hE3E7E8E9_00000000_00000000_00000000);
            // ctrl entries that wrap below zero stay as they are
            key_map[MapCtl]['h97] = 8'hE0;
            key_map[MapCtl]['hB5] = 8'hEF;
            latched_flags = '0;
            failures = 0;
            shown = 0;
        endfunction

        // sixteen entries, first one in the top byte
        function void load_row(int m, int base, logic [127:0] row);
            for (int i = 0; i < 16; i++)
                key_map[m][base + i] = row[127 - 8*i -: 8];
        endfunction

        function scs1a_pkg::flags_t modifier_mask(scs1a_pkg::byte_t key);
            scs1a_pkg::flags_t m;
            m = '0;
            if (key == scs1a_pkg::CodeLCtl || key == scs1a_pkg::CodeRCtl)
                m[scs1a_pkg::BitCtl] = 1'b1;
            if (key == scs1a_pkg::CodeLShift || key == scs1a_pkg::CodeRShift)
                m[scs1a_pkg::BitShift] = 1'b1;
            if (key == scs1a_pkg::CodeLAlt || key == scs1a_pkg::CodeRAlt)
                m[scs1a_pkg::BitAlt] = 1'b1;
            return m;
        endfunction

        function scs1a_pkg::flags_t toggle_mask(scs1a_pkg::byte_t key);
            scs1a_pkg::flags_t m;
            m = '0;
            m[scs1a_pkg::BitCaps]   = (key == scs1a_pkg::CodeCaps);
            m[scs1a_pkg::BitNum]    = (key == scs1a_pkg::CodeNum);
            m[scs1a_pkg::BitScroll] = (key == scs1a_pkg::CodeScroll);
            return m;
        endfunction

        // accepted scancode: update flags, queue the decoded word
        function void note_scancode(scs1a_pkg::byte_t sc);
            scs1a_pkg::byte_t  key;
            scs1a_pkg::flags_t fl;
            decoded_t          d;
            key = sc;
            fl = latched_flags;
            d.ch = '0;
            d.dbg = 1'b0;
            if (sc == scs1a_pkg::CodePrefix)
                fl[scs1a_pkg::BitPrefix] = 1'b1;
            else if (sc[7])
            begin
                // break code; bit 7 only survives after the prefix
                if (!fl[scs1a_pkg::BitPrefix])
                    key = sc & scs1a_pkg::CodeLowMask;
                fl = fl & ~modifier_mask(key);
                fl[scs1a_pkg::BitPrefix] = 1'b0;
            end
            else
            begin
                if (fl[scs1a_pkg::BitPrefix])
                begin
                    key = sc | scs1a_pkg::CodeRelease;
                    fl[scs1a_pkg::BitPrefix] = 1'b0;
                end
                fl = fl | modifier_mask(key);
                fl = fl ^ toggle_mask(key);
                if (fl[scs1a_pkg::BitCtl])
                    d.ch = key_map[MapCtl][key];
                else if (fl[scs1a_pkg::BitShift])
                    d.ch = key_map[MapShift][key];
                else
                    d.ch = key_map[MapPlain][key];
                if (fl[scs1a_pkg::BitCaps])
                begin
                    if (d.ch >= LowerA && d.ch <= LowerZ)
                        d.ch = d.ch - scs1a_pkg::CaseFlip;
                    else if (d.ch >= UpperA && d.ch <= UpperZ)
                        d.ch = d.ch + scs1a_pkg::CaseFlip;
                end
                d.dbg = fl[scs1a_pkg::BitCtl] && fl[scs1a_pkg::BitAlt]
                        && (d.ch == scs1a_pkg::CharDel);
            end
            latched_flags = fl;
            d.mods = fl;
            pending_chars.push_back(d);
        endfunction

        function void flag_error(string msg);
            failures++;
            if (shown < 10)
            begin
                shown++;
                $display("ERROR: %s", msg);
            end
        endfunction

        function void check_char(scs1a_pkg::byte_t ch, logic dbg, scs1a_pkg::flags_t mods);
            decoded_t want;
            if (pending_chars.size() == 0)
            begin
                flag_error($sformatf("unexpected word: char %h dbg %b flags %h",
                                     ch, dbg, mods));
                return;
            end
            want = pending_chars.pop_front();
            if (want.ch !== ch || want.dbg !== dbg || want.mods !== mods)
                flag_error($sformatf(
                    "expected char %h dbg %b flags %h, got char %h dbg %b flags %h",
                    want.ch, want.dbg, want.mods, ch, dbg, mods));
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction

    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] scancode = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] char_code;
    logic       debug_request;
    logic [6:0] modifier_state;

    scancode_checker sb;
    int  words_sent = 0;
    int  quiet_cycles = 0;
    // set for a window of words: neither side idles while it holds
    bit  steady = 1'b0;

    scs1a_pkg::byte_t mod_keys[7] = '{scs1a_pkg::CodeLCtl, scs1a_pkg::CodeLShift,
                                      scs1a_pkg::CodeRShift, scs1a_pkg::CodeLAlt,
                                      scs1a_pkg::CodeCaps, scs1a_pkg::CodeNum,
                                      scs1a_pkg::CodeScroll};

    // Directed opening: field extremes, case swap with caps and shift, double
    // prefix, keypad slash, ctrl wraparound, debug request, locks, bare breaks.
    scs1a_pkg::byte_t opening[26] = '{8'h00, 8'h7F, 8'h1E, scs1a_pkg::CodeCaps, 8'h1E,
                                      scs1a_pkg::CodeLShift, 8'h1E, 8'h02, 8'hAA,
                                      scs1a_pkg::CodeCaps, scs1a_pkg::CodePrefix,
                                      scs1a_pkg::CodePrefix, 8'h35, scs1a_pkg::CodeLCtl,
                                      8'h35, scs1a_pkg::CodeLAlt, scs1a_pkg::CodePrefix,
                                      8'h53, scs1a_pkg::CodePrefix, 8'hD3,
                                      scs1a_pkg::CodeRCtl, scs1a_pkg::CodeRAlt,
                                      scs1a_pkg::CodeNum, scs1a_pkg::CodeScroll, 8'hFF,
                                      scs1a_pkg::CodeRelease};

    scancode_set1_to_ascii_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .scancode       (scancode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_code      (char_code),
        .debug_request  (debug_request),
        .modifier_state (modifier_state)
    );

    always #5 clk = ~clk;

    // Receiver side: random stalls about a third of the time, none in the steady window.
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 34);

    // Both channels are observed at the same edge; the input word is noted first so
    // a prediction is always queued ahead of its result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_scancode(scancode);
            if (out_valid && !out_stall)
                sb.check_char(char_code, debug_request, modifier_state);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= IdleLimit)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Drive one word; returns on the edge that accepts it. The sender idles
    // at random beforehand, except in the steady window.
    task automatic send_word(input scs1a_pkg::byte_t sc);
        while (!steady && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        scancode <= sc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        steady = (words_sent >= 500) && (words_sent < 750);
    endtask

    // Ordinary key: optional E0 prefix, make code, usually the matching break.
    task automatic type_key();
        scs1a_pkg::byte_t key;
        bit               ext;
        ext = ($urandom_range(0, 3) == 0);
        key = scs1a_pkg::byte_t'($urandom_range(1, 'h58));
        if (ext)
            send_word(scs1a_pkg::CodePrefix);
        send_word(key);
        if ($urandom_range(0, 3) != 0)
        begin
            if (ext)
                send_word(scs1a_pkg::CodePrefix);
            send_word(key | scs1a_pkg::CodeRelease);
        end
    endtask

    // Modifier or lock key, pressed or released; ctrl and alt also as the right-hand
    // (prefixed) variants.
    task automatic toggle_modifier();
        scs1a_pkg::byte_t key;
        key = mod_keys[$urandom_range(0, 6)];
        if ((key == scs1a_pkg::CodeLCtl || key == scs1a_pkg::CodeLAlt)
            && $urandom_range(0, 1))
            send_word(scs1a_pkg::CodePrefix);
        if ($urandom_range(0, 1))
            send_word(key);
        else
            send_word(key | scs1a_pkg::CodeRelease);
    endtask

    // Ctrl+Alt+Del: hold both modifiers, hit the extended delete key, usually let go.
    task automatic ctrl_alt_del();
        if ($urandom_range(0, 1))
            send_word(scs1a_pkg::CodePrefix);
        send_word(scs1a_pkg::CodeLCtl);
        send_word(scs1a_pkg::CodeLAlt);
        send_word(scs1a_pkg::CodePrefix);
        send_word(8'h53);
        send_word(scs1a_pkg::CodePrefix);
        send_word(8'hD3);
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 1))
                send_word(scs1a_pkg::CodePrefix);
            send_word(scs1a_pkg::CodeRCtl);
            send_word(scs1a_pkg::CodeRAlt);
        end
    endtask

    initial
    begin
        int pick;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            send_word(opening[i]);

        // Mostly well-formed typing with modifiers, a little raw noise.
        while (words_sent < RandomWords)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_word(scs1a_pkg::byte_t'($urandom_range(0, 255)));
            else if (pick < 35)
                toggle_modifier();
            else if (pick < 90)
                type_key();
            else
                ctrl_alt_del();
        end
        in_valid <= 1'b0;

        // drain, then keep watching for any stray word
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/scs1a_pkg.sv
hw/rtl/scancode_set1_to_ascii_top.sv
hw/rtl/scs1a_checker.sv
tb/testbench.sv
